// File: rtl/xcrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcrs_pkg
// Types and constants shared by the code reference scanner modules.
// ----------------------------------------------------------------------------
package xcrs_pkg;

	localparam int unsigned COUNT_W = 31;
	localparam int unsigned ADDR_W  = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// instruction encodings
	localparam logic [7:0] REX_W_BYTE  = 8'h48;
	localparam logic [7:0] REX_WR_BYTE = 8'h4C;
	localparam logic [7:0] LEA_OPCODE  = 8'h8D;
	localparam logic [7:0] MODRM_MASK  = 8'hC7;
	localparam logic [7:0] MODRM_RIP   = 8'h05;
	localparam logic [7:0] CALL_OPCODE = 8'hE8;

	// instruction lengths; the last byte arrives (length - 1) bytes after the start
	localparam logic [2:0] LEA_LEN  = 3'd7;
	localparam logic [2:0] CALL_LEN = 3'd5;

	typedef enum logic {
		MODE_LEA  = 1'b0,
		MODE_CALL = 1'b1
	} scan_mode_t;

	typedef enum logic {
		KIND_MATCH = 1'b0,
		KIND_DONE  = 1'b1
	} result_kind_t;

	typedef enum logic [2:0] {
		REG_SCAN_MODE      = 3'd0,
		REG_TARGET_ADDRESS = 3'd1,
		REG_SECTION_BASE   = 3'd2,
		REG_SCAN_LENGTH    = 3'd3,
		REG_START_COUNT    = 3'd4,
		REG_SITE_CAPACITY  = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic               result_kind;
		logic [ADDR_W-1:0]  site_address;
		logic [COUNT_W-1:0] match_count;
		logic               site_stored;
	} out_item_t;

	// settings seen by the front
	typedef struct packed {
		scan_mode_t         scan_mode;
		logic [ADDR_W-1:0]  target_address;
		logic [ADDR_W-1:0]  section_base;
		logic [COUNT_W-1:0] scan_length;
	} front_cfg_t;

	// settings seen by the back
	typedef struct packed {
		logic [COUNT_W-1:0] start_count;
		logic [COUNT_W-1:0] site_capacity;
	} back_cfg_t;

	// one classified byte, front to back
	typedef struct packed {
		logic              hit;
		logic              fin;
		logic              reload;
		logic [ADDR_W-1:0] site;
	} entry_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// File: rtl/xcrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcrs_front
// Accept code bytes, keep the byte window and position, classify each byte.
// ----------------------------------------------------------------------------
module xcrs_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  xcrs_pkg::front_cfg_t  cfg,
	input  logic                  in_valid,
	input  xcrs_pkg::in_item_t    in_item,
	output logic                  in_stall,
	input  xcrs_pkg::queue_status_t q_status,
	output logic                  push,
	output xcrs_pkg::entry_t      push_entry
);

	logic [47:0] win_q;
	logic [31:0] pos_q;

	logic        v_s1;
	logic [55:0] w_s1;
	logic [31:0] start_s1;
	logic        ok_s1;
	logic        fin_s1;
	logic        reload_s1;

	logic        adv;
	logic        accept;
	logic [55:0] w_next;
	logic        past_thr;
	logic        in_bound;
	logic [31:0] start_next;

	logic [31:0] disp;
	logic [31:0] site;
	logic [34:0] expect_site;
	logic [34:0] len_ext;
	logic        pat_ok;

	assign adv      = !v_s1 || !q_status.full;
	assign in_stall = !adv;
	assign accept   = in_valid && adv;
	assign push     = v_s1 && !q_status.full;

	assign w_next = {win_q, in_item.code_byte};

	// start offset sits (length - 1) bytes behind the incoming byte
	always_comb begin
		if (cfg.scan_mode == xcrs_pkg::MODE_LEA) begin
			past_thr   = pos_q >= 32'(xcrs_pkg::LEA_LEN - 3'd1);
			start_next = pos_q - 32'(xcrs_pkg::LEA_LEN - 3'd1);
		end else begin
			past_thr   = pos_q >= 32'(xcrs_pkg::CALL_LEN - 3'd1);
			start_next = pos_q - 32'(xcrs_pkg::CALL_LEN - 3'd1);
		end
	end

	// start + length < scan_length reduces to pos + 1 < scan_length in both modes
	assign in_bound = ({1'b0, pos_q} + 33'd1) < {2'b0, cfg.scan_length};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			pos_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (accept) begin
				if (in_item.final_byte) begin
					win_q <= '0;
					pos_q <= '0;
				end else begin
					win_q <= w_next[47:0];
					pos_q <= pos_q + 32'd1;
				end
				v_s1 <= 1'b1;
			end else if (push) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			w_s1      <= w_next;
			start_s1  <= start_next;
			ok_s1     <= past_thr && in_bound;
			fin_s1    <= in_item.final_byte;
			reload_s1 <= pos_q == 32'd0;
		end
	end

	// little-endian displacement, oldest byte least significant
	assign disp = {w_s1[7:0], w_s1[15:8], w_s1[23:16], w_s1[31:24]};

	always_comb begin
		if (cfg.scan_mode == xcrs_pkg::MODE_LEA) begin
			len_ext = 35'(xcrs_pkg::LEA_LEN);
			pat_ok  = (w_s1[55:48] == xcrs_pkg::REX_W_BYTE ||
				w_s1[55:48] == xcrs_pkg::REX_WR_BYTE) &&
				w_s1[47:40] == xcrs_pkg::LEA_OPCODE &&
				(w_s1[39:32] & xcrs_pkg::MODRM_MASK) == xcrs_pkg::MODRM_RIP;
		end else begin
			len_ext = 35'(xcrs_pkg::CALL_LEN);
			pat_ok  = w_s1[39:32] == xcrs_pkg::CALL_OPCODE;
		end
	end

	// site + len + disp == target  <=>  site == target - len - disp, exact
	assign site        = cfg.section_base + start_s1;
	assign expect_site = {3'b0, cfg.target_address} - len_ext - {{3{disp[31]}}, disp};

	always_comb begin
		push_entry.hit    = ok_s1 && pat_ok && (expect_site == {3'b0, site});
		push_entry.fin    = fin_s1;
		push_entry.reload = reload_s1;
		push_entry.site   = site;
	end

endmodule

// File: rtl/xcrs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcrs_queue
// Short register queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module xcrs_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  xcrs_pkg::entry_t        push_entry,
	input  logic                    pop,
	output xcrs_pkg::entry_t        head,
	output xcrs_pkg::queue_status_t status
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	xcrs_pkg::entry_t slot_q [DEPTH];

	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] level_q;

	assign status.full  = level_q == CNT_W'(DEPTH);
	assign status.empty = level_q == '0;
	assign head         = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// File: rtl/xcrs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcrs_back
// Keep the running match count and emit match and done results.
// ----------------------------------------------------------------------------
module xcrs_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  xcrs_pkg::back_cfg_t     cfg,
	input  xcrs_pkg::entry_t        head,
	input  xcrs_pkg::queue_status_t q_status,
	output logic                    pop,
	output logic                    out_valid,
	output xcrs_pkg::out_item_t     out_item,
	input  logic                    out_stall
);

	logic [xcrs_pkg::COUNT_W-1:0] cnt_q;
	logic                         done_pend_q;
	logic                         out_valid_q;
	xcrs_pkg::out_item_t          out_item_q;

	logic                         load_ok;
	logic [xcrs_pkg::COUNT_W-1:0] cnt_b;
	logic [xcrs_pkg::COUNT_W-1:0] cnt_inc;
	logic                         emit_match;
	logic                         emit_done;
	logic                         silent;

	assign load_ok = !out_valid_q || !out_stall;

	// reload applies once per entry, before its match
	assign cnt_b   = (head.reload && !done_pend_q) ? cfg.start_count : cnt_q;
	assign cnt_inc = (cnt_b == xcrs_pkg::COUNT_MAX) ? cnt_b : cnt_b + 1'b1;

	assign emit_match = !q_status.empty && load_ok && head.hit && !done_pend_q;
	assign emit_done  = !q_status.empty && load_ok && head.fin &&
		(!head.hit || done_pend_q);
	assign silent     = !q_status.empty && !head.hit && !head.fin;

	assign pop = silent || emit_done || (emit_match && !head.fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			done_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_match) begin
				cnt_q       <= cnt_inc;
				done_pend_q <= head.fin;
			end else if (emit_done || silent) begin
				cnt_q       <= cnt_b;
				done_pend_q <= 1'b0;
			end
			if (emit_match || emit_done) begin
				out_valid_q <= 1'b1;
			end else if (load_ok) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_match) begin
			out_item_q.result_kind  <= xcrs_pkg::KIND_MATCH;
			out_item_q.site_address <= head.site;
			out_item_q.match_count  <= cnt_inc;
			out_item_q.site_stored  <= cnt_b < cfg.site_capacity;
		end else if (emit_done) begin
			out_item_q.result_kind  <= xcrs_pkg::KIND_DONE;
			out_item_q.site_address <= '0;
			out_item_q.match_count  <= cnt_b;
			out_item_q.site_stored  <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// File: rtl/x86_code_reference_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_code_reference_scanner_top
// Scan a code section byte by byte for rip-relative lea or near call sites
// that refer to a target address.
// ----------------------------------------------------------------------------
// The block takes one code byte per beat and sustains one byte per clock
// while the queue is not full. A match is reported on the beat of the last
// pattern byte; its result then passes the front window register, a queue
// slot and the output register, in that order.
// The byte that carries final_byte and also completes a match yields two
// results, the match and then the done summary, and holds the back until both
// are sent; the queue of QUEUE_DEPTH entries between front and back absorbs
// that and any output stall before the input sees stall. Bytes that give no
// result drain from the queue at one per cycle regardless of the output side.
// Configuration writes are always ready and take effect on the next cycle;
// write them only while no scan is in flight. start_count is loaded into the
// running count when the byte at offset 0 of a scan is processed.
// ----------------------------------------------------------------------------
module x86_code_reference_scanner_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  xcrs_pkg::in_item_t  in_item,
	output logic                in_stall,
	output logic                out_valid,
	output xcrs_pkg::out_item_t out_item,
	input  logic                out_stall,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	// configuration registers
	xcrs_pkg::scan_mode_t         scan_mode_q;
	logic [xcrs_pkg::ADDR_W-1:0]  target_address_q;
	logic [xcrs_pkg::ADDR_W-1:0]  section_base_q;
	logic [xcrs_pkg::COUNT_W-1:0] scan_length_q;
	logic [xcrs_pkg::COUNT_W-1:0] start_count_q;
	logic [xcrs_pkg::COUNT_W-1:0] site_capacity_q;

	xcrs_pkg::front_cfg_t    front_cfg;
	xcrs_pkg::back_cfg_t     back_cfg;
	xcrs_pkg::entry_t        push_entry;
	xcrs_pkg::entry_t        head;
	xcrs_pkg::queue_status_t q_status;
	logic                    push;
	logic                    pop;

	// accept writes every cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode_q      <= xcrs_pkg::MODE_LEA;
			target_address_q <= '0;
			section_base_q   <= '0;
			scan_length_q    <= '0;
			start_count_q    <= '0;
			site_capacity_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				xcrs_pkg::REG_SCAN_MODE: begin
					scan_mode_q <= xcrs_pkg::scan_mode_t'(cfg_data[0]);
				end
				xcrs_pkg::REG_TARGET_ADDRESS: begin
					target_address_q <= cfg_data;
				end
				xcrs_pkg::REG_SECTION_BASE: begin
					section_base_q <= cfg_data;
				end
				xcrs_pkg::REG_SCAN_LENGTH: begin
					scan_length_q <= cfg_data[xcrs_pkg::COUNT_W-1:0];
				end
				xcrs_pkg::REG_START_COUNT: begin
					start_count_q <= cfg_data[xcrs_pkg::COUNT_W-1:0];
				end
				xcrs_pkg::REG_SITE_CAPACITY: begin
					site_capacity_q <= cfg_data[xcrs_pkg::COUNT_W-1:0];
				end
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	assign front_cfg.scan_mode      = scan_mode_q;
	assign front_cfg.target_address = target_address_q;
	assign front_cfg.section_base   = section_base_q;
	assign front_cfg.scan_length    = scan_length_q;
	assign back_cfg.start_count     = start_count_q;
	assign back_cfg.site_capacity   = site_capacity_q;

	// front: window, position, pattern and target compare
	xcrs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (front_cfg),
		.in_valid   (in_valid),
		.in_item    (in_item),
		.in_stall   (in_stall),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	// decouple classification from result delivery
	xcrs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	// back: running count, result sequencing, output register
	xcrs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (back_cfg),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_item  (out_item),
		.out_stall (out_stall)
	);

`ifndef SYNTH
	// a done summary carries no site
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.result_kind == xcrs_pkg::KIND_DONE |->
		out_item.site_address == '0 && !out_item.site_stored)
	else $error("done result carries site data");

	// a match count is taken after the increment, so it is never zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.result_kind == xcrs_pkg::KIND_MATCH |->
		out_item.match_count != '0)
	else $error("match result with zero count");

	// back never drains an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
	else $error("queue popped while empty");

	// front never overfills the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
	else $error("queue pushed while full");
`endif

endmodule
